@@ rtl/uid_pkg.sv @@
// Shared types and constants for the unique identifier table.
// Holds field widths, status and action codes, and the structs that pass
// between the sequencer and the top level. No dependencies.
package uid_pkg;

  // Field widths
  localparam int ID_W     = 27;
  localparam int ACT_W    = 2;
  localparam int STAT_W   = 3;
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Reset value of the identifier limit register
  localparam logic [ID_W-1:0] LIMIT_RESET = ID_W'(99999999);

  // Action codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_STORED  = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_INVALID = 3'd3,
    ST_READ    = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  // Memory access request from the sequencer
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [ID_W-1:0]  wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // Finished result handed to the output register
  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] position;
    logic [ID_W-1:0]  read_value;
  } result_t;

endpackage

@@ rtl/unique_id_table_insert.sv @@
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+------------------------------------------
// input     | in        | in_valid / in_stall | action, id_value, read_index
// result    | out       | out_valid/out_stall | status, position, read_value, entry_count
// config    | in        | cfg_we              | cfg_wdata (identifier upper limit)
//
// An insert searches the stored entries: the search reads one entry a
// cycle through the single read port of the entry memory. A read below the
// count waits on the registered memory read. One item is in work at a time.
// Reset empties the table and sets the limit to 99999999; entry memory
// contents are not cleared. A stalled result holds the next item in its
// final cycle until the output register is free.
// Top level of the identifier table. Depends on uid_pkg, uid_ram, uid_ctrl.
module unique_id_table_insert (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [uid_pkg::ACT_W-1:0]  action,
  input  logic [uid_pkg::ID_W-1:0]   id_value,
  input  logic [uid_pkg::IDX_W-1:0]  read_index,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [uid_pkg::STAT_W-1:0] status,
  output logic [uid_pkg::IDX_W-1:0]  position,
  output logic [uid_pkg::ID_W-1:0]   read_value,
  output logic [uid_pkg::CNT_W-1:0]  entry_count,
  input  logic                       cfg_we,
  input  logic [uid_pkg::ID_W-1:0]   cfg_wdata
);
  import uid_pkg::*;

  logic [ID_W-1:0]  id_upper_limit;
  logic [ID_W-1:0]  mem_rdata;
  mem_req_t         mem_req;
  result_t          res;
  logic             res_fire;
  logic             out_free;
  logic [CNT_W-1:0] count;

  assign out_free = !out_valid || !out_stall;

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      id_upper_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      id_upper_limit <= cfg_wdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res_fire) begin
        out_valid   <= 1'b1;
        status      <= res.status;
        position    <= res.position;
        read_value  <= res.read_value;
        entry_count <= count;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  uid_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .id_value       (id_value),
    .read_index     (read_index),
    .id_upper_limit (id_upper_limit),
    .mem_rdata      (mem_rdata),
    .mem_req        (mem_req),
    .out_free       (out_free),
    .res_fire       (res_fire),
    .res            (res),
    .count          (count)
  );

  uid_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ID_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ rtl/uid_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// Generic; no package dependency.
module uid_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 27,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/uid_ctrl.sv @@
// Sequencer for the identifier table: decodes items, runs the linear search
// over the entry memory, appends, reads and clears. Depends on uid_pkg.
module uid_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [uid_pkg::ACT_W-1:0]  action,
  input  logic [uid_pkg::ID_W-1:0]   id_value,
  input  logic [uid_pkg::IDX_W-1:0]  read_index,
  input  logic [uid_pkg::ID_W-1:0]   id_upper_limit,
  input  logic [uid_pkg::ID_W-1:0]   mem_rdata,
  output uid_pkg::mem_req_t          mem_req,
  input  logic                       out_free,
  output logic                       res_fire,
  output uid_pkg::result_t           res,
  output logic [uid_pkg::CNT_W-1:0]  count
);
  import uid_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_RDWAIT,
    S_DELIVER
  } state_t;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_t           state;
  logic [ID_W-1:0]  id_reg;
  logic [CNT_W-1:0] issue_idx;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;

  logic accept;
  logic hit;
  logic more;
  logic read_ok;
  logic id_bad;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign hit      = cmp_vld && (mem_rdata == id_reg);
  assign more     = (issue_idx < count);
  assign read_ok  = ({1'b0, read_index} < count);
  assign id_bad   = (id_value == '0) || (id_value > id_upper_limit);
  assign res_fire = (state == S_DELIVER) && out_free;

  // Memory requests: item read on transfer, search reads, append write
  always_comb begin
    mem_req       = '0;
    mem_req.wdata = id_reg;
    mem_req.waddr = count[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        mem_req.re    = accept && (action == ACT_READ) && read_ok;
        mem_req.raddr = read_index;
      end
      S_SEARCH: begin
        mem_req.re    = !hit && more;
        mem_req.raddr = issue_idx[IDX_W-1:0];
        mem_req.we    = !hit && !more && (count < CAP_CNT);
      end
      default: begin
        mem_req.re = 1'b0;
      end
    endcase
  end

  // State, count and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      cmp_vld <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            res.position   <= '0;
            res.read_value <= '0;
            res.status     <= ST_INVALID;
            state          <= S_DELIVER;
            case (action)
              ACT_INSERT: begin
                if (!id_bad) begin
                  id_reg    <= id_value;
                  issue_idx <= '0;
                  cmp_vld   <= 1'b0;
                  state     <= S_SEARCH;
                end
              end
              ACT_READ: begin
                if (read_ok) begin
                  res.position <= read_index;
                  state        <= S_RDWAIT;
                end
              end
              ACT_CLEAR: begin
                count      <= '0;
                res.status <= ST_CLEARED;
              end
              default: begin
                res.status <= ST_INVALID;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (hit) begin
            // match on the entry read last cycle
            res.status   <= ST_DUP;
            res.position <= cmp_idx;
            cmp_vld      <= 1'b0;
            state        <= S_DELIVER;
          end else if (more) begin
            cmp_vld   <= 1'b1;
            cmp_idx   <= issue_idx[IDX_W-1:0];
            issue_idx <= issue_idx + 1'b1;
          end else begin
            // every entry compared without a match
            cmp_vld <= 1'b0;
            state   <= S_DELIVER;
            if (count < CAP_CNT) begin
              res.status   <= ST_STORED;
              res.position <= count[IDX_W-1:0];
              count        <= count + 1'b1;
            end else begin
              res.status <= ST_FULL;
            end
          end
        end
        S_RDWAIT: begin
          res.status     <= ST_READ;
          res.read_value <= mem_rdata;
          state          <= S_DELIVER;
        end
        S_DELIVER: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/uid_checker.sv @@
// Port-level checks on the result channel of the identifier table.
// Depends on uid_pkg; bound to unique_id_table_insert.
module uid_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic [uid_pkg::STAT_W-1:0] status,
  input logic [uid_pkg::IDX_W-1:0]  position,
  input logic [uid_pkg::ID_W-1:0]   read_value,
  input logic [uid_pkg::CNT_W-1:0]  entry_count
);
  import uid_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Count never goes past capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_count <= CAP_CNT))
    else $error("entry_count above capacity");

  // A successful read lies below the count
  a_read_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_READ)) |-> ({1'b0, position} < entry_count))
    else $error("read position not below count");

  // Only reads return data
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_READ)) |-> (read_value == '0))
    else $error("read_value nonzero for non-read status");

  // An append lands at the old count
  a_append_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_STORED)) |->
      (entry_count == ({1'b0, position} + 1'b1)))
    else $error("stored position does not match count");

  // Clearing empties the table
  a_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_CLEARED)) |-> ((entry_count == '0) && (position == '0)))
    else $error("clear left entries or a position");

endmodule

bind unique_id_table_insert uid_checker u_uid_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .status      (status),
  .position    (position),
  .read_value  (read_value),
  .entry_count (entry_count)
);
